[design/sprle_pkg.sv]
// Shared types and constants of the sprite transparency run-length encoder.
package sprle_pkg;

  // Field widths
  localparam int unsigned OffW     = 19;
  localparam int unsigned SideW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned PixW     = 32;

  // Up to three writes come out of one pixel
  localparam int unsigned MaxWrites = 3;
  localparam int unsigned WrCntW    = 2;

  // Reset values and fixed steps
  localparam logic [SideW-1:0]  SideReset  = 8'd32;
  localparam logic [CountW-1:0] CountMax   = 16'hFFFF;
  localparam logic [OffW-1:0]   OffStart   = 19'd2;
  localparam logic [OffW-1:0]   CountBytes = 19'd2;
  localparam logic [OffW-1:0]   PixelBytes = 19'd4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgRegionWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRegionHeight = 1'b1;

  // Write kinds
  localparam logic KindCount = 1'b0;
  localparam logic KindPixel = 1'b1;

  // One input item
  typedef struct packed {
    logic [PixW-1:0] pixel_word;
    logic            is_clear;
  } pix_item_t;

  // One result item
  typedef struct packed {
    logic             write_kind;
    logic [OffW-1:0]  byte_offset;
    logic [PixW-1:0]  write_value;
    logic             final_write;
    logic [OffW-1:0]  total_bytes;
    logic [SideW-1:0] max_solid_x;
    logic [SideW-1:0] max_solid_y;
  } wr_item_t;

  // All writes caused by one pixel
  typedef struct packed {
    wr_item_t [MaxWrites-1:0] wr;
    logic [WrCntW-1:0]        cnt;
  } wr_bundle_t;

endpackage

[design/sprle_core.sv]
// Encoder state and per-pixel write generation.
module sprle_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sprle_pkg::SideW-1:0]  width_i,
  input  logic [sprle_pkg::SideW-1:0]  height_i,
  input  sprle_pkg::pix_item_t         item_i,
  input  logic                         step_i,
  output sprle_pkg::wr_bundle_t        bundle_o
);

  // Encoder state
  logic [sprle_pkg::CountW-1:0] run_q;
  logic                         in_clear_q;
  logic [sprle_pkg::OffW-1:0]   slot_q;
  logic [sprle_pkg::OffW-1:0]   next_q;
  logic [sprle_pkg::SideW-1:0]  col_q;
  logic [sprle_pkg::SideW-1:0]  row_q;
  logic [sprle_pkg::SideW-1:0]  best_x_q;
  logic [sprle_pkg::SideW-1:0]  best_y_q;
  logic                         first_seen_q;

  // Step values
  logic                         clear;
  logic                         first;
  logic                         open_zero;
  logic                         ic0;
  logic                         close;
  logic                         last_col;
  logic                         last;
  logic [sprle_pkg::SideW-1:0]  w_side;
  logic [sprle_pkg::SideW-1:0]  h_side;
  logic [sprle_pkg::SideW:0]    col_p1;
  logic [sprle_pkg::SideW:0]    row_p1;
  logic [sprle_pkg::OffW-1:0]   slot0;
  logic [sprle_pkg::OffW-1:0]   nxt0;
  logic [sprle_pkg::OffW-1:0]   slot1;
  logic [sprle_pkg::OffW-1:0]   nxt1;
  logic [sprle_pkg::OffW-1:0]   nxt2;
  logic [sprle_pkg::OffW-1:0]   total;
  logic [sprle_pkg::CountW-1:0] run1;
  logic [sprle_pkg::CountW-1:0] run2;
  logic [sprle_pkg::SideW-1:0]  best_x_d;
  logic [sprle_pkg::SideW-1:0]  best_y_d;
  sprle_pkg::wr_bundle_t        bundle;

  function automatic sprle_pkg::wr_item_t mk_wr(
    input logic                       kind,
    input logic [sprle_pkg::OffW-1:0] off,
    input logic [sprle_pkg::PixW-1:0] val
  );
    sprle_pkg::wr_item_t r;
    r             = '0;
    r.write_kind  = kind;
    r.byte_offset = off;
    r.write_value = val;
    return r;
  endfunction

  // Run bookkeeping: a run closes whenever the transparency flips
  always_comb begin
    clear     = item_i.is_clear;
    first     = !first_seen_q;
    w_side    = (width_i == '0) ? sprle_pkg::SideW'(1) : width_i;
    h_side    = (height_i == '0) ? sprle_pkg::SideW'(1) : height_i;
    col_p1    = {1'b0, col_q} + (sprle_pkg::SideW+1)'(1);
    row_p1    = {1'b0, row_q} + (sprle_pkg::SideW+1)'(1);
    last_col  = col_p1 >= {1'b0, w_side};
    last      = last_col && (row_p1 >= {1'b0, h_side});

    // solid first pixel opens with a zero transparent count
    open_zero = first && !clear;
    ic0       = first ? clear : in_clear_q;
    slot0     = open_zero ? sprle_pkg::CountBytes : slot_q;
    nxt0      = open_zero ? (sprle_pkg::CountBytes + sprle_pkg::CountBytes) : next_q;
    close     = ic0 ^ clear;

    slot1     = close ? nxt0 : slot0;
    nxt1      = close ? (nxt0 + sprle_pkg::CountBytes) : nxt0;
    run1      = close ? '0 : run_q;
    run2      = (run1 == sprle_pkg::CountMax) ? sprle_pkg::CountMax
                                              : run1 + sprle_pkg::CountW'(1);
    nxt2      = clear ? nxt1 : (nxt1 + sprle_pkg::PixelBytes);
    total     = (last && clear) ? (nxt2 + sprle_pkg::CountBytes) : nxt2;

    best_x_d  = (!clear && (col_q > best_x_q)) ? col_q : best_x_q;
    best_y_d  = (!clear && (row_q > best_y_q)) ? row_q : best_y_q;
  end

  // Pack the writes of this pixel in order
  always_comb begin
    bundle = '0;
    if (open_zero) begin
      bundle.wr[bundle.cnt] = mk_wr(sprle_pkg::KindCount, '0, '0);
      bundle.cnt            = bundle.cnt + sprle_pkg::WrCntW'(1);
    end
    if (close) begin
      bundle.wr[bundle.cnt] = mk_wr(sprle_pkg::KindCount, slot0,
                                    {{(sprle_pkg::PixW-sprle_pkg::CountW){1'b0}}, run_q});
      bundle.cnt            = bundle.cnt + sprle_pkg::WrCntW'(1);
    end
    if (!clear) begin
      bundle.wr[bundle.cnt] = mk_wr(sprle_pkg::KindPixel, nxt1, item_i.pixel_word);
      bundle.cnt            = bundle.cnt + sprle_pkg::WrCntW'(1);
    end
    if (last) begin
      bundle.wr[bundle.cnt] = mk_wr(sprle_pkg::KindCount, slot1,
                                    {{(sprle_pkg::PixW-sprle_pkg::CountW){1'b0}}, run2});
      bundle.cnt            = bundle.cnt + sprle_pkg::WrCntW'(1);
      // record ending transparent gets a trailing zero solid count
      if (clear) begin
        bundle.wr[bundle.cnt] = mk_wr(sprle_pkg::KindCount,
                                      slot1 + sprle_pkg::CountBytes, '0);
        bundle.cnt            = bundle.cnt + sprle_pkg::WrCntW'(1);
      end
      bundle.wr[bundle.cnt - sprle_pkg::WrCntW'(1)].final_write = 1'b1;
    end
    for (int i = 0; i < sprle_pkg::MaxWrites; i++) begin
      bundle.wr[i].total_bytes = total;
      bundle.wr[i].max_solid_x = best_x_d;
      bundle.wr[i].max_solid_y = best_y_d;
    end
  end

  assign bundle_o = bundle;

  // State update; the sprite's last pixel returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= '0;
      in_clear_q   <= 1'b0;
      slot_q       <= '0;
      next_q       <= sprle_pkg::OffStart;
      col_q        <= '0;
      row_q        <= '0;
      best_x_q     <= '0;
      best_y_q     <= '0;
      first_seen_q <= 1'b0;
    end else if (step_i) begin
      if (last) begin
        run_q        <= '0;
        in_clear_q   <= 1'b0;
        slot_q       <= '0;
        next_q       <= sprle_pkg::OffStart;
        col_q        <= '0;
        row_q        <= '0;
        best_x_q     <= '0;
        best_y_q     <= '0;
        first_seen_q <= 1'b0;
      end else begin
        run_q        <= run2;
        in_clear_q   <= clear;
        slot_q       <= slot1;
        next_q       <= nxt2;
        best_x_q     <= best_x_d;
        best_y_q     <= best_y_d;
        first_seen_q <= 1'b1;
        if (last_col) begin
          col_q <= '0;
          row_q <= row_p1[sprle_pkg::SideW-1:0];
        end else begin
          col_q <= col_p1[sprle_pkg::SideW-1:0];
        end
      end
    end
  end

endmodule

[design/sprle_outbuf.sv]
// Result buffer: holds the writes of one pixel and hands them out one per cycle while out_ready_i is high.
module sprle_outbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  sprle_pkg::wr_bundle_t bundle_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sprle_pkg::wr_item_t   out_item_o
);

  sprle_pkg::wr_item_t [sprle_pkg::MaxWrites-1:0] ent_q;
  logic [sprle_pkg::WrCntW-1:0] cnt_q;
  logic [sprle_pkg::WrCntW-1:0] idx_q;
  logic                         pop;
  logic                         last_pop;

  // Drain control
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign last_pop    = pop && (idx_q == (cnt_q - sprle_pkg::WrCntW'(1)));
  assign free_o      = (cnt_q == '0) || last_pop;
  assign out_item_o  = ent_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
      idx_q <= '0;
    end else if (last_pop) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (pop) begin
      idx_q <= idx_q + sprle_pkg::WrCntW'(1);
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= bundle_i.wr;
    end
  end

endmodule

[design/sprite_transparency_rle_encoder.sv]
// Top level of the sprite transparency run-length encoder.
//
// Pixels of a sprite region enter in raster order on the in_* channel
// (valid/ready), each a 32-bit word and a transparency flag. Memory writes
// that build the run-length record leave on the out_* channel (valid/ready):
// counts as 16-bit values, solid pixels as 32-bit words, each with its byte
// offset, the running record length and the greatest solid column and row.
// The region size sits in two registers written through cfg_we_i,
// cfg_index_i and cfg_data_i; write them only between sprites.
// An accepted item passes the input register and the result buffer before
// its first write leaves. A pixel causes zero to three writes; the buffer
// sends one write per cycle while out_ready_i is high, so the rate
// is one pixel per cycle when each pixel causes at most one write.
// A transparent pixel that causes no write passes without using the buffer.
// Reset clears the encoder state and sets both sides to 32. When the receiver
// stalls, the buffer holds its writes, one more pixel waits in the input
// register, and then in_ready_o falls.
module sprite_transparency_rle_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sprle_pkg::pix_item_t              in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sprle_pkg::wr_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [sprle_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sprle_pkg::SideW-1:0]       cfg_data_i
);

  logic                        in_valid_q;
  sprle_pkg::pix_item_t        in_item_q;
  logic [sprle_pkg::SideW-1:0] width_q;
  logic [sprle_pkg::SideW-1:0] height_q;
  sprle_pkg::wr_bundle_t       bundle;
  logic                        buf_free;
  logic                        process;
  logic                        load;
  logic                        accept;

  // Handshake: a pixel with no writes proceeds even when the buffer is busy
  assign process    = in_valid_q && ((bundle.cnt == '0) || buf_free);
  assign load       = process && (bundle.cnt != '0);
  assign in_ready_o = !in_valid_q || process;
  assign accept     = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sprle_pkg::SideReset;
      height_q <= sprle_pkg::SideReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sprle_pkg::CfgRegionWidth:  width_q  <= cfg_data_i;
        sprle_pkg::CfgRegionHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sprle_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_q),
    .height_i (height_q),
    .item_i   (in_item_q),
    .step_i   (process),
    .bundle_o (bundle)
  );

  sprle_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[design/sprle_checker.sv]
// Port-level checks of the encoder, bound to the top level.
module sprle_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input sprle_pkg::wr_item_t               out_item_o
);

  // A stalled write holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled write changed");

  // Offsets and lengths advance in two-byte steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_item_o.byte_offset[0] && !out_item_o.total_bytes[0])
    else $error("odd byte offset or length");

  // Count writes carry only 16 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.write_kind == sprle_pkg::KindCount)
      |-> (out_item_o.write_value[31:16] == '0))
    else $error("count write wider than 16 bits");

  // Input backpressure only comes from pending writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no write pending");

endmodule

bind sprite_transparency_rle_encoder sprle_checker u_sprle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

[dv/sprle_checker.sv]
// Scoreboard for the sprite run-length encoder: predicts every write and checks the output.
module sprle_scoreboard (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  sprle_pkg::pix_item_t            in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  sprle_pkg::wr_item_t             out_item_i,
  input  logic                            cfg_we_i,
  input  logic [sprle_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sprle_pkg::SideW-1:0]     cfg_data_i,
  output int unsigned                     fail_cnt_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Region registers as the block should see them
  logic [sprle_pkg::SideW-1:0]  reg_width;
  logic [sprle_pkg::SideW-1:0]  reg_height;

  // Encoder state
  logic [sprle_pkg::CountW-1:0] run_len;
  logic                         in_gap;
  logic [sprle_pkg::OffW-1:0]   slot_off;
  logic [sprle_pkg::OffW-1:0]   next_off;
  logic [sprle_pkg::SideW-1:0]  col;
  logic [sprle_pkg::SideW-1:0]  row;
  logic [sprle_pkg::SideW-1:0]  max_x;
  logic [sprle_pkg::SideW-1:0]  max_y;
  logic                         started;

  // Writes predicted but not yet seen on the output
  sprle_pkg::wr_item_t          write_q[$];
  int unsigned                  writes_seen;

  function automatic void clear_encoder();
    run_len  = '0;
    in_gap   = 1'b0;
    slot_off = '0;
    next_off = sprle_pkg::OffStart;
    col      = '0;
    row      = '0;
    max_x    = '0;
    max_y    = '0;
    started  = 1'b0;
  endfunction

  function automatic sprle_pkg::wr_item_t mk_write(logic kind,
                                                   logic [sprle_pkg::OffW-1:0] off,
                                                   logic [sprle_pkg::PixW-1:0] val);
    sprle_pkg::wr_item_t w;
    w             = '0;
    w.write_kind  = kind;
    w.byte_offset = off;
    w.write_value = val;
    return w;
  endfunction

  // A run ends: its count slot moves to the next free offset
  function automatic void end_run();
    slot_off = next_off;
    next_off = next_off + sprle_pkg::CountBytes;
    run_len  = '0;
  endfunction

  function automatic void bump_run();
    if (run_len != sprle_pkg::CountMax) run_len = run_len + 1'b1;
  endfunction

  // Work out the writes one pixel causes and queue them
  function automatic void encode_pixel(sprle_pkg::pix_item_t px);
    sprle_pkg::wr_item_t        step_q[$];
    int unsigned                side_w;
    int unsigned                side_h;
    logic                       last_col;
    logic                       last_px;
    logic [sprle_pkg::OffW-1:0] total;
    side_w   = (reg_width == '0) ? 1 : int'(reg_width);
    side_h   = (reg_height == '0) ? 1 : int'(reg_height);
    last_col = (int'(col) + 1 >= side_w);
    last_px  = last_col && (int'(row) + 1 >= side_h);

    // Record opening: a solid start gets a zero transparent count at offset 0
    if (!started) begin
      started = 1'b1;
      if (px.is_clear) begin
        in_gap = 1'b1;
      end else begin
        step_q.push_back(mk_write(sprle_pkg::KindCount, '0, '0));
        in_gap   = 1'b0;
        slot_off = sprle_pkg::OffStart;
        next_off = sprle_pkg::OffStart + sprle_pkg::CountBytes;
      end
    end

    if (!px.is_clear) begin
      if (col > max_x) max_x = col;
      if (row > max_y) max_y = row;
      if (in_gap) begin
        step_q.push_back(mk_write(sprle_pkg::KindCount, slot_off,
                                  sprle_pkg::PixW'(run_len)));
        end_run();
        in_gap = 1'b0;
      end
      step_q.push_back(mk_write(sprle_pkg::KindPixel, next_off, px.pixel_word));
      next_off = next_off + sprle_pkg::PixelBytes;
      bump_run();
    end else begin
      if (!in_gap) begin
        step_q.push_back(mk_write(sprle_pkg::KindCount, slot_off,
                                  sprle_pkg::PixW'(run_len)));
        end_run();
        in_gap = 1'b1;
      end
      bump_run();
    end

    // Last pixel: close the open run, trailing zero solid count if transparent
    total = next_off;
    if (last_px) begin
      step_q.push_back(mk_write(sprle_pkg::KindCount, slot_off,
                                sprle_pkg::PixW'(run_len)));
      if (in_gap) begin
        step_q.push_back(mk_write(sprle_pkg::KindCount,
                                  slot_off + sprle_pkg::CountBytes, '0));
        total = next_off + sprle_pkg::CountBytes;
      end
      step_q[step_q.size() - 1].final_write = 1'b1;
    end

    foreach (step_q[i]) begin
      step_q[i].total_bytes = total;
      step_q[i].max_solid_x = max_x;
      step_q[i].max_solid_y = max_y;
      write_q.push_back(step_q[i]);
    end

    // Advance the raster position; a finished sprite starts over
    if (last_px) begin
      clear_encoder();
    end else if (last_col) begin
      col = '0;
      row = row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
  endfunction

  function automatic void note_failure(string msg);
    if (fail_cnt_o < 10) $display("%0t ns sprle_scoreboard: %s", $realtime, msg);
    fail_cnt_o = fail_cnt_o + 1;
  endfunction

  function automatic void cmp_field(string name, logic [sprle_pkg::PixW-1:0] want,
                                    logic [sprle_pkg::PixW-1:0] got);
    if (got !== want) begin
      note_failure($sformatf("write %0d %s: expected %h, got %h",
                             writes_seen, name, want, got));
    end
  endfunction

  // Compare one output write against the oldest prediction
  function automatic void check_write(sprle_pkg::wr_item_t got);
    sprle_pkg::wr_item_t want;
    if (write_q.size() == 0) begin
      note_failure($sformatf("write %0d arrived with nothing expected: %h",
                             writes_seen, got));
      writes_seen = writes_seen + 1;
      return;
    end
    want = write_q.pop_front();
    cmp_field("write_kind",  sprle_pkg::PixW'(want.write_kind),
              sprle_pkg::PixW'(got.write_kind));
    cmp_field("byte_offset", sprle_pkg::PixW'(want.byte_offset),
              sprle_pkg::PixW'(got.byte_offset));
    cmp_field("write_value", want.write_value, got.write_value);
    cmp_field("final_write", sprle_pkg::PixW'(want.final_write),
              sprle_pkg::PixW'(got.final_write));
    cmp_field("total_bytes", sprle_pkg::PixW'(want.total_bytes),
              sprle_pkg::PixW'(got.total_bytes));
    cmp_field("max_solid_x", sprle_pkg::PixW'(want.max_solid_x),
              sprle_pkg::PixW'(got.max_solid_x));
    cmp_field("max_solid_y", sprle_pkg::PixW'(want.max_solid_y),
              sprle_pkg::PixW'(got.max_solid_y));
    writes_seen = writes_seen + 1;
  endfunction

  // Watch the three ports at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_width  = sprle_pkg::SideReset;
      reg_height = sprle_pkg::SideReset;
      clear_encoder();
      write_q.delete();
      writes_seen = 0;
      fail_cnt_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_write(out_item_i);
      if (in_valid_i && in_ready_i) encode_pixel(in_item_i);
      if (cfg_we_i) begin
        if (cfg_index_i == sprle_pkg::CfgRegionWidth) begin
          reg_width = cfg_data_i;
        end else if (cfg_index_i == sprle_pkg::CfgRegionHeight) begin
          reg_height = cfg_data_i;
        end
      end
    end
    pending_o = write_q.size();
  end

endmodule

[dv/tb_top.sv]
// Top of the sprite run-length encoder testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandItems     = 100;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 4000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  sprle_pkg::pix_item_t          in_item = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  sprle_pkg::wr_item_t           out_item;
  logic                          cfg_we = 1'b0;
  logic [sprle_pkg::CfgIdxW-1:0] cfg_index = sprle_pkg::CfgRegionWidth;
  logic [sprle_pkg::SideW-1:0]   cfg_data = '0;

  int unsigned        fail_cnt;
  int unsigned        pending;
  int unsigned        idle_cycles = 0;
  bit                 no_idle = 1'b0;
  bit                 hold_out = 1'b0;

  sprite_transparency_rle_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sprle_scoreboard u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Share of transparent pixels for a random sprite
  function automatic int unsigned clear_pct_pick();
    case ($urandom_range(0, 2))
      0: return 10;
      1: return 50;
      default: return 90;
    endcase
  endfunction

  // Offer one pixel and wait until it is taken
  task automatic send_pixel(logic clr, logic [sprle_pkg::PixW-1:0] word);
    int unsigned gap;
    gap = (no_idle || $urandom_range(0, 9) < 6) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{pixel_word: word, is_clear: clr};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Pixels in runs; clear_pct sets how transparent the sprite is
  task automatic send_sprite(int unsigned n_px, int unsigned clear_pct, bit solid_end);
    logic clr;
    clr = ($urandom_range(0, 99) < clear_pct);
    for (int unsigned i = 0; i < n_px; i++) begin
      if ($urandom_range(0, 9) < 3) clr = ($urandom_range(0, 99) < clear_pct);
      if (solid_end && i == n_px - 1) clr = 1'b0;
      send_pixel(clr, $urandom());
    end
  endtask

  // Both region registers, one per cycle
  task automatic set_region(logic [sprle_pkg::SideW-1:0] width,
                            logic [sprle_pkg::SideW-1:0] height);
    cfg_we    <= 1'b1;
    cfg_index <= sprle_pkg::CfgRegionWidth;
    cfg_data  <= width;
    @(posedge clk_i);
    cfg_index <= sprle_pkg::CfgRegionHeight;
    cfg_data  <= height;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Stop offering and let every write drain, plus a margin for silent pixels
  task automatic settle();
    in_valid <= 1'b0;
    do begin
      while (pending != 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end while (pending != 0);
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned len;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 9) < 6) begin
        out_ready <= 1'b1;
        len = $urandom_range(1, 8);
        repeat (len) @(posedge clk_i);
      end else begin
        out_ready <= 1'b0;
        len = idle_len();
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned n_px;
    int unsigned sent;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x2 sprite that opens solid and ends transparent
    set_region(8'd3, 8'd2);
    send_pixel(1'b0, 32'hFFFF_FFFF);
    send_pixel(1'b1, 32'h0000_0000);
    send_pixel(1'b1, 32'h1234_5678);
    send_pixel(1'b0, 32'h0000_0000);
    send_pixel(1'b0, 32'hA5A5_A5A5);
    send_pixel(1'b1, 32'h5A5A_5A5A);
    // 3x2 sprite that opens transparent and ends solid
    send_pixel(1'b1, 32'hFFFF_FFFF);
    send_pixel(1'b1, 32'hDEAD_BEEF);
    send_pixel(1'b0, 32'h5A5A_5A5A);
    send_pixel(1'b0, 32'hFFFF_FFFF);
    send_pixel(1'b1, 32'h0000_0001);
    send_pixel(1'b0, 32'h8000_0000);
    settle();

    // Zero sizes behave as 1x1: one transparent and one solid sprite
    set_region(8'd0, 8'd0);
    send_pixel(1'b1, 32'h0F0F_0F0F);
    send_pixel(1'b0, 32'hF0F0_F0F0);
    settle();

    // Region narrows under a sprite in progress
    set_region(8'd4, 8'd3);
    repeat (6) send_pixel(1'($urandom_range(0, 1)), $urandom());
    settle();
    set_region(8'd1, 8'd3);
    send_pixel(1'b0, $urandom());
    send_pixel(1'b1, $urandom());
    settle();

    // Widest row, with the receiver held off to back up the block
    no_idle  = 1'b1;
    hold_out = 1'b1;
    set_region(8'd255, 8'd1);
    send_sprite(255, 50, 1'b1);
    settle();
    no_idle = 1'b0;

    // Tall narrow column, mostly transparent
    set_region(8'd1, 8'd40);
    send_sprite(40, 90, 1'b1);
    settle();

    // Small random sprites, some cut short by the next region change
    sent = 0;
    while (sent < RandItems) begin
      w    = $urandom_range(0, 8);
      h    = $urandom_range(0, 6);
      n_px = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      if ($urandom_range(0, 6) == 0) n_px = $urandom_range(1, n_px);
      no_idle = ($urandom_range(0, 3) == 0);
      set_region(w[sprle_pkg::SideW-1:0], h[sprle_pkg::SideW-1:0]);
      send_sprite(n_px, clear_pct_pick(), 1'($urandom_range(0, 1)));
      settle();
      sent = sent + n_px;
    end

    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
